// File: rtl/mm_pkg.sv
// ----------------------------------------------------------------------------
// mm_pkg: shared types and constants of the matrix multiply engine
// Request and result layouts, action codes, register indexes and the
// control bundle that the sequencer hands to the cell chain.
// ----------------------------------------------------------------------------
package mm_pkg;

	localparam int ELEM_W      = 16;
	localparam int ACC_W       = 35;
	localparam int FIELD_W     = 3;
	localparam int CFG_W       = 4;
	localparam int ACT_W       = 2;
	localparam int APB_AW      = 4;
	localparam int APB_DW      = 32;
	localparam int MAX_DIM_DEF = 8;

	localparam logic [ACT_W-1:0] ACT_WRITE_A = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WRITE_B = 2'd1;
	localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

	localparam logic [1:0] REG_ROWS  = 2'd0;
	localparam logic [1:0] REG_INNER = 2'd1;
	localparam logic [1:0] REG_COLS  = 2'd2;

	localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

	typedef struct packed {
		logic [ACT_W-1:0]         action;
		logic [FIELD_W-1:0]       row_index;
		logic [FIELD_W-1:0]       col_index;
		logic signed [ELEM_W-1:0] element_value;
	} req_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] product_value;
		logic [FIELD_W-1:0]      out_row;
		logic [FIELD_W-1:0]      out_col;
		logic                    last_flag;
	} rsp_t;

	typedef struct packed {
		logic                     wr_a;
		logic                     wr_b;
		logic [FIELD_W-1:0]       wr_row;
		logic [FIELD_W-1:0]       wr_col;
		logic signed [ELEM_W-1:0] wr_data;
		logic                     rd_en;
		logic [FIELD_W-1:0]       rd_row;
		logic [FIELD_W-1:0]       rd_k;
		logic                     acc_en;
		logic                     acc_first;
		logic                     shift;
	} ctl_t;

	function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
		input logic [CFG_W-1:0] hi);
		logic [CFG_W-1:0] r;
		r = v;
		if (v == '0) r = CFG_W'(1);
		else if (v > hi) r = hi;
		return r;
	endfunction

endpackage

// File: rtl/matrix_multiply.sv
// ----------------------------------------------------------------------------
// matrix_multiply: dense fixed-point matrix product engine
// Stores A and B element by element and streams out C = A x B in row-major
// order on a compute request, with the final element marked.
// ----------------------------------------------------------------------------
// A write request for A or B is written while busy stays low, so writes
// may follow each other every cycle. A compute request raises busy while,
// per result row, the chain of column cells does one multiply-accumulate
// per inner index, drains the multiplier pipeline (its a_s1/b_s1 and
// prod_s2 registers), and shifts the sums out of the chain column by column.
// Each result is registered and shown in the cycle after its shift, so
// the last result appears in the first cycle with busy low. Each result
// is shown for one cycle with result_valid and must be taken then; the
// receiver cannot stall.
module matrix_multiply #(
	parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mm_pkg::APB_AW-1:0]    paddr,
	input  logic [mm_pkg::APB_DW-1:0]    pwdata,
	output logic [mm_pkg::APB_DW-1:0]    prdata,
	output logic                         pready,
	input  logic                         start,
	input  mm_pkg::req_t                 req,
	output logic                         busy,
	output mm_pkg::rsp_t                 result,
	output logic                         result_valid
);

	logic [mm_pkg::CFG_W-1:0]        rows_q, inner_q, cols_q;
	logic [mm_pkg::CFG_W-1:0]        nr, nk, nc;
	logic [1:0]                      reg_idx;
	mm_pkg::ctl_t                    ctl;
	logic signed [mm_pkg::ELEM_W-1:0] a_mem [MAX_DIM][MAX_DIM];
	logic signed [mm_pkg::ELEM_W-1:0] a_s1;
	logic signed [mm_pkg::ACC_W-1:0]  acc_chain [MAX_DIM+1];

	localparam int IDX_W = $clog2(MAX_DIM);

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	always_comb begin
		case (reg_idx)
			mm_pkg::REG_ROWS:  prdata = mm_pkg::APB_DW'(rows_q);
			mm_pkg::REG_INNER: prdata = mm_pkg::APB_DW'(inner_q);
			mm_pkg::REG_COLS:  prdata = mm_pkg::APB_DW'(cols_q);
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= mm_pkg::DIM_RESET;
			inner_q <= mm_pkg::DIM_RESET;
			cols_q  <= mm_pkg::DIM_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				mm_pkg::REG_ROWS:  rows_q  <= pwdata[mm_pkg::CFG_W-1:0];
				mm_pkg::REG_INNER: inner_q <= pwdata[mm_pkg::CFG_W-1:0];
				mm_pkg::REG_COLS:  cols_q  <= pwdata[mm_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	assign nr = mm_pkg::clamp_dim(rows_q, mm_pkg::CFG_W'(MAX_DIM));
	assign nk = mm_pkg::clamp_dim(inner_q, mm_pkg::CFG_W'(MAX_DIM));
	assign nc = mm_pkg::clamp_dim(cols_q, mm_pkg::CFG_W'(MAX_DIM));

	always_ff @(posedge clk) begin
		if (ctl.wr_a) begin
			a_mem[ctl.wr_row[IDX_W-1:0]][ctl.wr_col[IDX_W-1:0]] <= ctl.wr_data;
		end
		if (ctl.rd_en) begin
			a_s1 <= a_mem[ctl.rd_row[IDX_W-1:0]][ctl.rd_k[IDX_W-1:0]];
		end
	end

	mm_ctrl #(
		.MAX_DIM(MAX_DIM)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.req          (req),
		.nr           (nr),
		.nk           (nk),
		.nc           (nc),
		.acc0         (acc_chain[0]),
		.busy         (busy),
		.ctl          (ctl),
		.result       (result),
		.result_valid (result_valid)
	);

	assign acc_chain[MAX_DIM] = '0;

	for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
		mm_cell #(
			.MAX_DIM(MAX_DIM),
			.COL    (c)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.a_s1    (a_s1),
			.acc_in  (acc_chain[c+1]),
			.acc_out (acc_chain[c])
		);
	end

endmodule

// File: rtl/mm_cell.sv
// ----------------------------------------------------------------------------
// mm_cell: one column cell of the product chain
// Holds one column of B, multiplies it by the broadcast A element and
// accumulates one result element; shifts its sum to its neighbor on unload.
// ----------------------------------------------------------------------------
module mm_cell #(
	parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF,
	parameter int COL     = 0
) (
	input  logic                             clk,
	input  mm_pkg::ctl_t                     ctl,
	input  logic signed [mm_pkg::ELEM_W-1:0] a_s1,
	input  logic signed [mm_pkg::ACC_W-1:0]  acc_in,
	output logic signed [mm_pkg::ACC_W-1:0]  acc_out
);

	localparam int IDX_W = $clog2(MAX_DIM);

	logic signed [mm_pkg::ELEM_W-1:0]   bank_q [MAX_DIM];
	logic signed [mm_pkg::ELEM_W-1:0]   b_s1;
	logic signed [2*mm_pkg::ELEM_W-1:0] prod_s2;
	logic signed [mm_pkg::ACC_W-1:0]    acc_q;
	logic signed [mm_pkg::ACC_W-1:0]    prod_ext;

	assign prod_ext = mm_pkg::ACC_W'(prod_s2);
	assign acc_out  = acc_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_b && ctl.wr_col == mm_pkg::FIELD_W'(COL)) begin
			bank_q[ctl.wr_row[IDX_W-1:0]] <= ctl.wr_data;
		end
		if (ctl.rd_en) begin
			b_s1 <= bank_q[ctl.rd_k[IDX_W-1:0]];
		end
		prod_s2 <= a_s1 * b_s1;
		if (ctl.shift) begin
			acc_q <= acc_in;
		end else if (ctl.acc_en) begin
			acc_q <= ctl.acc_first ? prod_ext : acc_q + prod_ext;
		end
	end

endmodule

// File: rtl/mm_ctrl.sv
// ----------------------------------------------------------------------------
// mm_ctrl: sequencer of the matrix multiply engine
// Decodes requests, walks rows and the inner dimension, drains the
// multiply pipeline and unloads the cell chain into the result register.
// ----------------------------------------------------------------------------
module mm_ctrl #(
	parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  mm_pkg::req_t                    req,
	input  logic [mm_pkg::CFG_W-1:0]        nr,
	input  logic [mm_pkg::CFG_W-1:0]        nk,
	input  logic [mm_pkg::CFG_W-1:0]        nc,
	input  logic signed [mm_pkg::ACC_W-1:0] acc0,
	output logic                            busy,
	output mm_pkg::ctl_t                    ctl,
	output mm_pkg::rsp_t                    result,
	output logic                            result_valid
);

	localparam int IDX_W = $clog2(MAX_DIM);

	typedef enum logic [1:0] {S_IDLE, S_MAC, S_DRAIN, S_UNLOAD} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   i_q, j_q, k_q;
	logic               drain_q;
	logic               v_s1, first_s1, v_s2, first_s2;
	mm_pkg::rsp_t       result_q;
	logic               result_valid_q;
	logic               accept, in_range, last_row, last_col;

	assign busy     = state_q != S_IDLE;
	assign accept   = start && !busy;
	assign in_range = mm_pkg::CFG_W'(req.row_index) < mm_pkg::CFG_W'(MAX_DIM)
		&& mm_pkg::CFG_W'(req.col_index) < mm_pkg::CFG_W'(MAX_DIM);
	assign last_row = mm_pkg::CFG_W'(i_q) == nr - mm_pkg::CFG_W'(1);
	assign last_col = mm_pkg::CFG_W'(j_q) == nc - mm_pkg::CFG_W'(1);

	always_comb begin
		ctl.wr_a      = accept && in_range && req.action == mm_pkg::ACT_WRITE_A;
		ctl.wr_b      = accept && in_range && req.action == mm_pkg::ACT_WRITE_B;
		ctl.wr_row    = req.row_index;
		ctl.wr_col    = req.col_index;
		ctl.wr_data   = req.element_value;
		ctl.rd_en     = state_q == S_MAC;
		ctl.rd_row    = mm_pkg::FIELD_W'(i_q);
		ctl.rd_k      = mm_pkg::FIELD_W'(k_q);
		ctl.acc_en    = v_s2;
		ctl.acc_first = first_s2;
		ctl.shift     = state_q == S_UNLOAD;
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			i_q            <= '0;
			j_q            <= '0;
			k_q            <= '0;
			drain_q        <= 1'b0;
			v_s1           <= 1'b0;
			first_s1       <= 1'b0;
			v_s2           <= 1'b0;
			first_s2       <= 1'b0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			v_s1           <= state_q == S_MAC;
			first_s1       <= k_q == '0;
			v_s2           <= v_s1;
			first_s2       <= first_s1;
			case (state_q)
				S_IDLE: begin
					if (accept && req.action == mm_pkg::ACT_COMPUTE) begin
						state_q <= S_MAC;
						i_q     <= '0;
						k_q     <= '0;
					end
				end
				S_MAC: begin
					if (mm_pkg::CFG_W'(k_q) == nk - mm_pkg::CFG_W'(1)) begin
						state_q <= S_DRAIN;
						drain_q <= 1'b0;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				S_DRAIN: begin
					if (drain_q) begin
						state_q <= S_UNLOAD;
						j_q     <= '0;
					end else begin
						drain_q <= 1'b1;
					end
				end
				S_UNLOAD: begin
					result_valid_q         <= 1'b1;
					result_q.product_value <= acc0;
					result_q.out_row       <= mm_pkg::FIELD_W'(i_q);
					result_q.out_col       <= mm_pkg::FIELD_W'(j_q);
					result_q.last_flag     <= last_row && last_col;
					if (last_col) begin
						if (last_row) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_MAC;
							i_q     <= i_q + IDX_W'(1);
							k_q     <= '0;
						end
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/mm_chk.sv
// ----------------------------------------------------------------------------
// mm_chk: port-level checks of the matrix multiply engine
// Watches the request, busy, result and pready ports and is bound to the top level.
// ----------------------------------------------------------------------------
module mm_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         start,
	input mm_pkg::req_t req,
	input logic         busy,
	input mm_pkg::rsp_t result,
	input logic         result_valid,
	input logic         pready
);

	// More results of the same product are still to come.
	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_flag |-> busy)
		else $error("busy low before the last result");

	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.action == mm_pkg::ACT_COMPUTE |=> busy)
		else $error("compute request did not raise busy");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_flag |=> !result_valid)
		else $error("result after the last element");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !(start && req.action == mm_pkg::ACT_COMPUTE) |=> !result_valid)
		else $error("result without a compute request");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind matrix_multiply mm_chk u_mm_chk (.*);

// File: bench/tb_matrix_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_multiply: self-checking bench for the matrix multiply engine
// Loads A and B element by element, issues compute requests under several
// dimension settings written over APB, and checks every streamed product
// element against a predictor held in the bench.
// ----------------------------------------------------------------------------
module tb_matrix_multiply;

	localparam int DIM = 8;
	localparam int QUIET_LIMIT = 2000;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [mm_pkg::APB_AW-1:0]   paddr;
	logic [mm_pkg::APB_DW-1:0]   pwdata;
	logic [mm_pkg::APB_DW-1:0]   prdata;
	logic                        pready;
	logic                        start;
	mm_pkg::req_t                req;
	logic                        busy;
	mm_pkg::rsp_t                result;
	logic                        result_valid;

	logic signed [mm_pkg::ELEM_W-1:0] a_copy [DIM*DIM];
	logic signed [mm_pkg::ELEM_W-1:0] b_copy [DIM*DIM];
	logic [mm_pkg::CFG_W-1:0]         dim_reg [3];
	mm_pkg::rsp_t                     expected_products [$];
	int                               fail_count = 0;
	int                               quiet_cycles = 0;
	bit                               gaps_on;

	matrix_multiply dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .req(req), .busy(busy), .result(result),
		.result_valid(result_valid)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_dim(input logic [mm_pkg::CFG_W-1:0] v);
		if (v == 0) return 1;
		if (v > DIM) return DIM;
		return int'(v);
	endfunction

	function automatic void predict_request(input mm_pkg::req_t r);
		int nr, nk, nc;
		logic signed [mm_pkg::ACC_W-1:0] sum;
		mm_pkg::rsp_t e;
		if (r.action == mm_pkg::ACT_WRITE_A) begin
			a_copy[r.row_index*DIM + r.col_index] = r.element_value;
		end else if (r.action == mm_pkg::ACT_WRITE_B) begin
			b_copy[r.row_index*DIM + r.col_index] = r.element_value;
		end else if (r.action == mm_pkg::ACT_COMPUTE) begin
			nr = eff_dim(dim_reg[mm_pkg::REG_ROWS]);
			nk = eff_dim(dim_reg[mm_pkg::REG_INNER]);
			nc = eff_dim(dim_reg[mm_pkg::REG_COLS]);
			for (int i = 0; i < nr; i++)
				for (int j = 0; j < nc; j++) begin
					sum = '0;
					for (int k = 0; k < nk; k++)
						sum += mm_pkg::ACC_W'(a_copy[i*DIM+k] * b_copy[k*DIM+j]);
					e.product_value = sum;
					e.out_row = mm_pkg::FIELD_W'(i);
					e.out_col = mm_pkg::FIELD_W'(j);
					e.last_flag = (i == nr-1) && (j == nc-1);
					expected_products.push_back(e);
				end
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_products.size() == 0) begin
				$display("%0t: unexpected product element %p", $time, result);
				fail_count++;
			end else begin
				if (result !== expected_products[0]) begin
					$display("%0t: product mismatch expected %p actual %p",
						$time, expected_products[0], result);
					fail_count++;
				end
				void'(expected_products.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_valid) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("matrix_multiply verification failed");
			$finish;
		end
	end

	task automatic send_request(input mm_pkg::req_t r);
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < 14) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_request(r);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (expected_products.size() != 0 || busy) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_dim(input logic [1:0] idx, input logic [mm_pkg::CFG_W-1:0] v);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= mm_pkg::APB_AW'(idx) << 2;
		pwdata <= mm_pkg::APB_DW'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		dim_reg[idx] = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_dims(input int nr, input int nk, input int nc);
		wait_drained();
		write_dim(mm_pkg::REG_ROWS, mm_pkg::CFG_W'(nr));
		write_dim(mm_pkg::REG_INNER, mm_pkg::CFG_W'(nk));
		write_dim(mm_pkg::REG_COLS, mm_pkg::CFG_W'(nc));
	endtask

	function automatic mm_pkg::req_t make_req(input logic [mm_pkg::ACT_W-1:0] act,
		input int r, input int c, input logic [mm_pkg::ELEM_W-1:0] v);
		mm_pkg::req_t q;
		q.action = act;
		q.row_index = mm_pkg::FIELD_W'(r);
		q.col_index = mm_pkg::FIELD_W'(c);
		q.element_value = v;
		return q;
	endfunction

	function automatic logic [mm_pkg::ELEM_W-1:0] pick_value();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'hffff;
			default: return mm_pkg::ELEM_W'($urandom);
		endcase
	endfunction

	task automatic fill_all(input bit extreme);
		for (int i = 0; i < DIM; i++)
			for (int j = 0; j < DIM; j++) begin
				send_request(make_req(mm_pkg::ACT_WRITE_A, i, j,
					extreme ? 16'h8000 : pick_value()));
				send_request(make_req(mm_pkg::ACT_WRITE_B, i, j,
					extreme ? 16'h8000 : pick_value()));
			end
	endtask

	task automatic test_directed();
		set_dims(1, 1, 1);
		send_request(make_req(mm_pkg::ACT_WRITE_A, 0, 0, 16'h7fff));
		send_request(make_req(mm_pkg::ACT_WRITE_B, 0, 0, 16'h8000));
		send_request(make_req(mm_pkg::ACT_COMPUTE, 5, 2, 16'h1234));
		send_request(make_req(2'd3, 0, 0, 16'h0000));
		send_request(make_req(mm_pkg::ACT_WRITE_A, 0, 0, 16'h8000));
		send_request(make_req(mm_pkg::ACT_COMPUTE, 0, 0, 16'h0000));
		set_dims(0, 15, 9);
	endtask

	task automatic test_extreme_sum();
		fill_all(1'b1);
		send_request(make_req(mm_pkg::ACT_COMPUTE, 0, 0, 16'h0000));
		set_dims(8, 8, 8);
		send_request(make_req(mm_pkg::ACT_COMPUTE, 7, 7, 16'hffff));
	endtask

	task automatic test_random_products();
		int nr, nk, nc, n;
		fill_all(1'b0);
		for (int round = 0; round < 30; round++) begin
			gaps_on = (round < 10 || round >= 20);
			if (round % 5 == 0) begin
				nr = $urandom_range(8, 1);
				nk = $urandom_range(8, 1);
				nc = $urandom_range(8, 1);
				if (round == 15) begin nr = 8; nk = 1; nc = 8; end
				set_dims(nr, nk, nc);
			end
			n = $urandom_range(10, 4);
			for (int w = 0; w < n; w++) begin
				if ($urandom_range(9) == 0)
					send_request(make_req(2'd3, $urandom, $urandom,
						mm_pkg::ELEM_W'($urandom)));
				else
					send_request(make_req(mm_pkg::ACT_W'($urandom_range(1)),
						$urandom_range(7), $urandom_range(7), pick_value()));
			end
			send_request(make_req(mm_pkg::ACT_COMPUTE, $urandom, $urandom,
				mm_pkg::ELEM_W'($urandom)));
			if (round == 12) wait_drained();
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		req = '0;
		gaps_on = 1'b1;
		for (int i = 0; i < 3; i++) dim_reg[i] = mm_pkg::DIM_RESET;
		for (int i = 0; i < DIM*DIM; i++) begin
			a_copy[i] = '0;
			b_copy[i] = '0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_extreme_sum();
		test_random_products();
		wait_drained();

		if (fail_count == 0)
			$display("matrix_multiply verification clean");
		else
			$display("matrix_multiply verification failed");
		$finish;
	end

endmodule
